[src/dlcg_pkg.sv]
// Package for the distance link contact generator.
// Holds widths, register indexes and the sideband types shared by all modules.
// Depends on nothing.
package dlcg_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;

   localparam int FIELD_W = 32;
   localparam int DIFF_W  = 33;
   localparam int MAG_W   = 32;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int SUM_W   = SQ_W + 2;
   localparam int LF_SHIFT = 28;
   localparam int RAD_W   = 96;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int LEN_SHIFT = 14;
   localparam int LEN_W   = ROOT_W - LEN_SHIFT;
   localparam int NUM_W   = MAG_W + LF_SHIFT + 1;
   localparam int QUO_W   = 15;
   localparam int NORM_W  = 16;
   localparam int PEN_W   = 32;
   localparam int REST_W  = 31;
   localparam int RESTN_W = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_KIND   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTITUTION = 2'd2;

   localparam logic KIND_CABLE = 1'b0;
   localparam logic KIND_ROD   = 1'b1;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  anchor;
   } sqrt_side_type;

   typedef struct packed {
      logic [2:0]         neg;
      logic               flip;
      logic               emit;
      logic               lf_zero;
      logic [PEN_W-1:0]   pen;
      logic [RESTN_W-1:0] rst;
      logic               anchor;
   } div_side_type;

endpackage

[src/dlcg_if.sv]
// Channel interfaces of the distance link contact generator.
// Depends on dlcg_pkg for the field widths.
interface dlcg_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dlcg_pkg::FIELD_W-1:0]   first_x;
   logic signed [dlcg_pkg::FIELD_W-1:0]   first_y;
   logic signed [dlcg_pkg::FIELD_W-1:0]   first_z;
   logic signed [dlcg_pkg::FIELD_W-1:0]   second_x;
   logic signed [dlcg_pkg::FIELD_W-1:0]   second_y;
   logic signed [dlcg_pkg::FIELD_W-1:0]   second_z;
   logic                                  second_is_anchor;

   modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   second_is_anchor, input ready);
   modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 second_is_anchor, output ready);
endinterface

interface dlcg_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [dlcg_pkg::NORM_W-1:0]    normal_x;
   logic signed [dlcg_pkg::NORM_W-1:0]    normal_y;
   logic signed [dlcg_pkg::NORM_W-1:0]    normal_z;
   logic [dlcg_pkg::PEN_W-1:0]            penetration;
   logic [dlcg_pkg::RESTN_W-1:0]          contact_restitution;
   logic                                  anchored_contact;

   modport source (output valid, normal_x, normal_y, normal_z, penetration,
                   contact_restitution, anchored_contact, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, penetration,
                 contact_restitution, anchored_contact, output ready);
endinterface

[src/dlcg_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Depends on dlcg_pkg for widths and the sideband type.
module dlcg_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  logic [dlcg_pkg::RAD_W-1:0]     in_radicand,
   input  dlcg_pkg::sqrt_side_type        in_side,
   output logic                           out_valid,
   output logic [dlcg_pkg::ROOT_W-1:0]    out_root,
   output dlcg_pkg::sqrt_side_type        out_side
);
   localparam int STAGES = dlcg_pkg::ROOT_W;
   localparam int REM_W  = dlcg_pkg::ROOT_W + 2;

   logic                          valid_ff [STAGES];
   logic [REM_W-1:0]              rem_ff   [STAGES];
   logic [dlcg_pkg::ROOT_W-1:0]   root_ff  [STAGES];
   logic [dlcg_pkg::RAD_W-1:0]    rad_ff   [STAGES];
   dlcg_pkg::sqrt_side_type       side_ff  [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_step
      logic                        valid_cur;
      logic [REM_W-1:0]            rem_cur;
      logic [dlcg_pkg::ROOT_W-1:0] root_cur;
      logic [dlcg_pkg::RAD_W-1:0]  rad_cur;
      dlcg_pkg::sqrt_side_type     side_cur;
      logic [REM_W-1:0]            rem_shift;
      logic [REM_W-1:0]            trial;
      logic                        take;

      if (g == 0) begin : g_head
         assign valid_cur = in_valid;
         assign rem_cur   = '0;
         assign root_cur  = '0;
         assign rad_cur   = in_radicand;
         assign side_cur  = in_side;
      end else begin : g_body
         assign valid_cur = valid_ff[g-1];
         assign rem_cur   = rem_ff[g-1];
         assign root_cur  = root_ff[g-1];
         assign rad_cur   = rad_ff[g-1];
         assign side_cur  = side_ff[g-1];
      end

      assign rem_shift = {rem_cur[REM_W-3:0], rad_cur[dlcg_pkg::RAD_W-1 -: 2]};
      assign trial     = {root_cur, 2'b01};
      assign take      = (rem_shift >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (enable) begin
            valid_ff[g] <= valid_cur;
         end
         if (enable) begin
            rem_ff[g]  <= take ? (rem_shift - trial) : rem_shift;
            root_ff[g] <= {root_cur[dlcg_pkg::ROOT_W-2:0], take};
            rad_ff[g]  <= {rad_cur[dlcg_pkg::RAD_W-3:0], 2'b00};
            side_ff[g] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

[src/dlcg_div.sv]
// Pipelined three-lane restoring divider, one quotient bit per register stage.
// Depends on dlcg_pkg for widths and the sideband type.
module dlcg_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic [2:0][dlcg_pkg::NUM_W-1:0]        in_num,
   input  logic [dlcg_pkg::ROOT_W-1:0]            in_den,
   input  dlcg_pkg::div_side_type                 in_side,
   output logic                                   out_valid,
   output logic [2:0][dlcg_pkg::QUO_W-1:0]        out_quo,
   output dlcg_pkg::div_side_type                 out_side
);
   localparam int STAGES = dlcg_pkg::QUO_W;
   localparam int CMP_W  = dlcg_pkg::NUM_W + 1;

   logic                                valid_ff [STAGES];
   logic [2:0][dlcg_pkg::NUM_W-1:0]     num_ff   [STAGES];
   logic [2:0][dlcg_pkg::QUO_W-1:0]     quo_ff   [STAGES];
   logic [dlcg_pkg::ROOT_W-1:0]         den_ff   [STAGES];
   dlcg_pkg::div_side_type              side_ff  [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_step
      logic                             valid_cur;
      logic [2:0][dlcg_pkg::NUM_W-1:0]  num_cur;
      logic [2:0][dlcg_pkg::QUO_W-1:0]  quo_cur;
      logic [dlcg_pkg::ROOT_W-1:0]      den_cur;
      dlcg_pkg::div_side_type           side_cur;
      logic [CMP_W-1:0]                 den_shift;
      logic [2:0][dlcg_pkg::NUM_W-1:0]  num_in;
      logic [2:0][dlcg_pkg::QUO_W-1:0]  quo_in;

      if (g == 0) begin : g_head
         assign valid_cur = in_valid;
         assign num_cur   = in_num;
         assign quo_cur   = '0;
         assign den_cur   = in_den;
         assign side_cur  = in_side;
      end else begin : g_body
         assign valid_cur = valid_ff[g-1];
         assign num_cur   = num_ff[g-1];
         assign quo_cur   = quo_ff[g-1];
         assign den_cur   = den_ff[g-1];
         assign side_cur  = side_ff[g-1];
      end

      assign den_shift = CMP_W'(den_cur) << (STAGES - 1 - g);

      always_comb begin
         logic [CMP_W-1:0] diff;
         logic             take;
         for (int l = 0; l < 3; l++) begin
            diff = CMP_W'(num_cur[l]) - den_shift;
            take = (CMP_W'(num_cur[l]) >= den_shift);
            num_in[l] = take ? diff[dlcg_pkg::NUM_W-1:0] : num_cur[l];
            quo_in[l] = {quo_cur[l][dlcg_pkg::QUO_W-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (enable) begin
            valid_ff[g] <= valid_cur;
         end
         if (enable) begin
            num_ff[g]  <= num_in;
            quo_ff[g]  <= quo_in;
            den_ff[g]  <= den_cur;
            side_ff[g] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

[src/distance_link_contact_generator_core.sv]
// One link word is accepted per cycle while the output is not stalled.
// The path is difference, squares, sum, 48 square root stages, decision,
// 15 divider stages and the output register; all stages advance together.
// A stalled output holds the whole pipeline and drops request ready.
// Synchronous reset clears the valid bits and the registers to cable mode, zero.
// Top level; depends on dlcg_pkg, dlcg_if, dlcg_sqrt and dlcg_div.
module distance_link_contact_generator_core #(
   parameter int POSITION_BITS = dlcg_pkg::POSITION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   dlcg_req_if.sink                            req_chan,
   dlcg_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [dlcg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dlcg_pkg::CSR_DATA_W-1:0]     csr_data
);
   localparam int CW = (POSITION_BITS > 32) ? 32 : POSITION_BITS;

   function automatic logic signed [dlcg_pkg::DIFF_W-1:0] coord(input logic [31:0] v);
      return signed'({{(dlcg_pkg::DIFF_W - CW){v[CW-1]}}, v[CW-1:0]});
   endfunction

   logic                                link_kind_ff;
   logic [dlcg_pkg::REST_W-1:0]         rest_length_ff;
   logic [dlcg_pkg::RESTN_W-1:0]        restitution_ff;

   logic                                enable;
   logic                                rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_kind_ff   <= dlcg_pkg::KIND_CABLE;
         rest_length_ff <= '0;
         restitution_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            dlcg_pkg::CSR_LINK_KIND:   link_kind_ff   <= csr_data[0];
            dlcg_pkg::CSR_REST_LENGTH: rest_length_ff <= csr_data[dlcg_pkg::REST_W-1:0];
            dlcg_pkg::CSR_RESTITUTION: restitution_ff <= csr_data[dlcg_pkg::RESTN_W-1:0];
            default: ;
         endcase
      end
   end

   assign enable         = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = enable;

   // Difference stage.
   logic signed [dlcg_pkg::DIFF_W-1:0]  diff [3];
   dlcg_pkg::sqrt_side_type             s1_side_in;
   dlcg_pkg::sqrt_side_type             s1_side_ff;
   logic                                s1_valid_ff;

   assign diff[0] = coord(req_chan.second_x) - coord(req_chan.first_x);
   assign diff[1] = coord(req_chan.second_y) - coord(req_chan.first_y);
   assign diff[2] = coord(req_chan.second_z) - coord(req_chan.first_z);

   always_comb begin
      logic [dlcg_pkg::DIFF_W-1:0] mag;
      s1_side_in.anchor = req_chan.second_is_anchor;
      for (int i = 0; i < 3; i++) begin
         mag = diff[i][dlcg_pkg::DIFF_W-1] ? 33'(-diff[i]) : 33'(diff[i]);
         s1_side_in.neg[i] = diff[i][dlcg_pkg::DIFF_W-1];
         s1_side_in.mag[i] = mag[dlcg_pkg::MAG_W-1:0];
      end
   end

   // Square and sum stages.
   logic [2:0][dlcg_pkg::SQ_W-1:0]      s2_sq_ff;
   dlcg_pkg::sqrt_side_type             s2_side_ff;
   logic                                s2_valid_ff;
   logic [dlcg_pkg::SUM_W-1:0]          s3_sum_ff;
   dlcg_pkg::sqrt_side_type             s3_side_ff;
   logic                                s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_chan.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (enable) begin
         s1_side_ff <= s1_side_in;
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= dlcg_pkg::SQ_W'(s1_side_ff.mag[i])
                           * dlcg_pkg::SQ_W'(s1_side_ff.mag[i]);
         end
         s2_side_ff <= s1_side_ff;
         s3_sum_ff  <= dlcg_pkg::SUM_W'(s2_sq_ff[0]) + dlcg_pkg::SUM_W'(s2_sq_ff[1])
                       + dlcg_pkg::SUM_W'(s2_sq_ff[2]);
         s3_side_ff <= s2_side_ff;
      end
   end

   // Square root of the sum scaled by 2^28.
   logic                                sq_valid;
   logic [dlcg_pkg::ROOT_W-1:0]         sq_root;
   dlcg_pkg::sqrt_side_type             sq_side;
   logic [dlcg_pkg::RAD_W-1:0]          radicand;

   assign radicand = {2'b00, s3_sum_ff, {dlcg_pkg::LF_SHIFT{1'b0}}};

   dlcg_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .enable      (enable),
      .in_valid    (s3_valid_ff),
      .in_radicand (radicand),
      .in_side     (s3_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // Decision stage: contact test, penetration and divider numerators.
   logic [dlcg_pkg::LEN_W-1:0]          len;
   logic [dlcg_pkg::LEN_W-1:0]          rest_ext;
   logic [dlcg_pkg::LEN_W-1:0]          excess;
   logic                                longer;
   logic                                equal;
   dlcg_pkg::div_side_type              dec_side_in;
   logic [2:0][dlcg_pkg::NUM_W-1:0]     dec_num_in;
   dlcg_pkg::div_side_type              dec_side_ff;
   logic [2:0][dlcg_pkg::NUM_W-1:0]     dec_num_ff;
   logic [dlcg_pkg::ROOT_W-1:0]         dec_lf_ff;
   logic                                dec_valid_ff;

   assign len      = sq_root[dlcg_pkg::ROOT_W-1:dlcg_pkg::LEN_SHIFT];
   assign rest_ext = dlcg_pkg::LEN_W'(rest_length_ff);
   assign longer   = (len > rest_ext);
   assign equal    = (len == rest_ext);

   always_comb begin
      dec_side_in.neg    = sq_side.neg;
      dec_side_in.anchor = sq_side.anchor;
      dec_side_in.lf_zero = (sq_root == '0);
      if (link_kind_ff == dlcg_pkg::KIND_ROD) begin
         dec_side_in.emit = !equal;
         dec_side_in.flip = !equal && !longer;
         dec_side_in.rst  = '0;
      end else begin
         dec_side_in.emit = longer;
         dec_side_in.flip = 1'b0;
         dec_side_in.rst  = restitution_ff;
      end
      excess = dec_side_in.flip ? (rest_ext - len) : (len - rest_ext);
      dec_side_in.pen = (excess[dlcg_pkg::LEN_W-1:dlcg_pkg::PEN_W] != '0) ? '1
                        : excess[dlcg_pkg::PEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
         dec_num_in[i] = dlcg_pkg::NUM_W'({sq_side.mag[i], {dlcg_pkg::LF_SHIFT{1'b0}}})
                         + dlcg_pkg::NUM_W'(sq_root[dlcg_pkg::ROOT_W-1:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (enable) begin
         dec_valid_ff <= sq_valid;
      end
      if (enable) begin
         dec_side_ff <= dec_side_in;
         dec_num_ff  <= dec_num_in;
         dec_lf_ff   <= sq_root;
      end
   end

   // Normal components by division with rounding.
   logic                                dv_valid;
   logic [2:0][dlcg_pkg::QUO_W-1:0]     dv_quo;
   dlcg_pkg::div_side_type              dv_side;

   dlcg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (dec_valid_ff),
      .in_num    (dec_num_ff),
      .in_den    (dec_lf_ff),
      .in_side   (dec_side_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Output register.
   logic signed [dlcg_pkg::NORM_W-1:0]  normal_in [3];
   logic signed [dlcg_pkg::NORM_W-1:0]  normal_ff [3];
   logic [dlcg_pkg::PEN_W-1:0]          pen_ff;
   logic [dlcg_pkg::RESTN_W-1:0]        rst_ff;
   logic                                anchor_ff;

   always_comb begin
      logic signed [dlcg_pkg::NORM_W-1:0] mag;
      for (int i = 0; i < 3; i++) begin
         mag = signed'({1'b0, dv_quo[i]});
         if (dv_side.lf_zero) begin
            normal_in[i] = '0;
         end else if (dv_side.neg[i] ^ dv_side.flip) begin
            normal_in[i] = -mag;
         end else begin
            normal_in[i] = mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid && dv_side.emit;
      end
      if (enable) begin
         normal_ff[0] <= normal_in[0];
         normal_ff[1] <= normal_in[1];
         normal_ff[2] <= normal_in[2];
         pen_ff       <= dv_side.pen;
         rst_ff       <= dv_side.rst;
         anchor_ff    <= dv_side.anchor;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.normal_x            = normal_ff[0];
   assign rsp_chan.normal_y            = normal_ff[1];
   assign rsp_chan.normal_z            = normal_ff[2];
   assign rsp_chan.penetration         = pen_ff;
   assign rsp_chan.contact_restitution = rst_ff;
   assign rsp_chan.anchored_contact    = anchor_ff;

   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("Output word valid after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> pen_ff != '0)
      else $error("Contact word with zero penetration.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (normal_ff[0] >= -16'sd16384 && normal_ff[0] <= 16'sd16384
                        && normal_ff[1] >= -16'sd16384 && normal_ff[1] <= 16'sd16384
                        && normal_ff[2] >= -16'sd16384 && normal_ff[2] <= 16'sd16384))
      else $error("Normal component outside the unit range.");

endmodule

[tb/tb_distance_link_contact_generator_core.sv]
// Testbench for distance_link_contact_generator_core: drives link words with random
// gaps and output stalls, predicts each contact word and compares it field by field.
// Depends on dlcg_pkg, dlcg_if and the core RTL.
module tb_distance_link_contact_generator_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] fx, fy, fz, sx, sy, sz;
      logic               anchor;
   } link_type;

   typedef struct {
      logic signed [15:0] nx, ny, nz;
      logic [31:0]        pen;
      logic [15:0]        rst;
      logic               anchor;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [dlcg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [dlcg_pkg::CSR_DATA_W-1:0] csr_data = '0;

   dlcg_req_if req_chan();
   dlcg_rsp_if rsp_chan();

   distance_link_contact_generator_core i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   logic        kind_q = dlcg_pkg::KIND_CABLE;
   logic [30:0] rest_q = '0;
   logic [15:0] restn_q = '0;
   contact_type pending_contacts[$];
   int          mismatch_count = 0;
   bit          quiet = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.first_x = '0;
      req_chan.first_y = '0;
      req_chan.first_z = '0;
      req_chan.second_x = '0;
      req_chan.second_y = '0;
      req_chan.second_z = '0;
      req_chan.second_is_anchor = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   function automatic bit predict_contact(input link_type w, output contact_type c);
      logic signed [32:0] d[3];
      logic [32:0]        m[3];
      logic [95:0]        rad, cand, num;
      logic [47:0]        lf;
      logic [33:0]        len, pen;
      logic [14:0]        q;
      bit                 flip;
      d[0] = {w.sx[31], w.sx} - {w.fx[31], w.fx};
      d[1] = {w.sy[31], w.sy} - {w.fy[31], w.fy};
      d[2] = {w.sz[31], w.sz} - {w.fz[31], w.fz};
      rad = '0;
      for (int i = 0; i < 3; i++) begin
         m[i] = d[i][32] ? -d[i] : d[i];
         rad += 96'(m[i]) * 96'(m[i]);
      end
      rad = rad << 28;
      lf = '0;
      for (int b = 47; b >= 0; b--) begin
         cand = 96'(lf | (48'd1 << b));
         if (cand * cand <= rad) lf = cand[47:0];
      end
      len = 34'(lf >> 14);
      flip = 1'b0;
      if (kind_q == dlcg_pkg::KIND_CABLE) begin
         if (len <= 34'(rest_q)) return 1'b0;
         pen = len - 34'(rest_q);
         c.rst = restn_q;
      end else begin
         if (len == 34'(rest_q)) return 1'b0;
         if (len > 34'(rest_q)) begin
            pen = len - 34'(rest_q);
         end else begin
            pen = 34'(rest_q) - len;
            flip = 1'b1;
         end
         c.rst = '0;
      end
      c.pen = (pen > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : pen[31:0];
      for (int i = 0; i < 3; i++) begin
         if (lf == 0) begin
            q = '0;
         end else begin
            num = (96'(m[i]) << 28) + 96'(lf >> 1);
            q = 15'(num / 96'(lf));
         end
         if (d[i][32] ^ flip) begin
            if (i == 0) c.nx = -16'(q);
            if (i == 1) c.ny = -16'(q);
            if (i == 2) c.nz = -16'(q);
         end else begin
            if (i == 0) c.nx = 16'(q);
            if (i == 1) c.ny = 16'(q);
            if (i == 2) c.nz = 16'(q);
         end
      end
      c.anchor = w.anchor;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      contact_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_contacts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected contact word: pen %h", rsp_chan.penetration);
         end else begin
            e = pending_contacts.pop_front();
            if (rsp_chan.normal_x !== e.nx || rsp_chan.normal_y !== e.ny ||
                rsp_chan.normal_z !== e.nz || rsp_chan.penetration !== e.pen ||
                rsp_chan.contact_restitution !== e.rst ||
                rsp_chan.anchored_contact !== e.anchor) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Contact mismatch: expected n %0d %0d %0d pen %h rst %h anc %b",
                           e.nx, e.ny, e.nz, e.pen, e.rst, e.anchor);
                  $display("                  got      n %0d %0d %0d pen %h rst %h anc %b",
                           rsp_chan.normal_x, rsp_chan.normal_y, rsp_chan.normal_z,
                           rsp_chan.penetration, rsp_chan.contact_restitution,
                           rsp_chan.anchored_contact);
               end
            end
         end
      end
   end

   // Output stalls come in bursts; none once the quiet stretch begins.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = $urandom_range(1, 10);
         if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_chan.ready = 1'b1;
            repeat (n) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   task automatic send_link(input link_type w);
      contact_type c;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.first_x = w.fx;
      req_chan.first_y = w.fy;
      req_chan.first_z = w.fz;
      req_chan.second_x = w.sx;
      req_chan.second_y = w.sy;
      req_chan.second_z = w.sz;
      req_chan.second_is_anchor = w.anchor;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (predict_contact(w, c)) pending_contacts.push_back(c);
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_contacts.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_reg(input logic [dlcg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [30:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == dlcg_pkg::CSR_LINK_KIND) kind_q = value[0];
      if (idx == dlcg_pkg::CSR_REST_LENGTH) rest_q = value;
      if (idx == dlcg_pkg::CSR_RESTITUTION) restn_q = value[15:0];
   endtask

   task automatic configure(input logic kind, input logic [30:0] rest, input logic [30:0] rn);
      drain();
      write_reg(dlcg_pkg::CSR_LINK_KIND, {30'(0), kind});
      write_reg(dlcg_pkg::CSR_REST_LENGTH, rest);
      write_reg(dlcg_pkg::CSR_RESTITUTION, rn);
   endtask

   function automatic link_type make_link(input int fx, fy, fz, sx, sy, sz, input bit anc);
      link_type w;
      w.fx = fx; w.fy = fy; w.fz = fz; w.sx = sx; w.sy = sy; w.sz = sz;
      w.anchor = anc;
      return w;
   endfunction

   // Mostly links whose length lands near the rest length, some fully random.
   function automatic link_type random_link();
      link_type w;
      int       off;
      w = make_link($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) begin
         off = int'(rest_q) + $urandom_range(0, 8) - 4;
         if ($urandom_range(0, 1)) off = -off;
         w.fx = $signed($urandom) >>> 2;
         w.fy = $signed($urandom) >>> 2;
         w.fz = $signed($urandom) >>> 2;
         w.sx = w.fx; w.sy = w.fy; w.sz = w.fz;
         case ($urandom_range(0, 3))
            0: w.sx = w.fx + off;
            1: w.sy = w.fy + off;
            2: w.sz = w.fz + off;
            default: begin
               w.sx = w.fx + $signed($urandom_range(0, 2 * 4096)) - 4096;
               w.sy = w.fy + off;
            end
         endcase
      end
      return w;
   endfunction

   task automatic test_cable_directed();
      configure(dlcg_pkg::KIND_CABLE, '0, 31'hFFFF);
      send_link(make_link(0, 0, 0, 0, 0, 0, 1'b0));
      send_link(make_link(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      send_link(make_link(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1'b0));
      send_link(make_link(0, 0, 0, 0, 32'h0001_0000, 0, 1'b1));
      configure(dlcg_pkg::KIND_CABLE, 31'h0003_0000, 31'h7FFF_FFFF);
      send_link(make_link(0, 0, 0, 32'h0003_0000, 0, 0, 1'b0));
      send_link(make_link(0, 0, 0, 32'h0003_0001, 0, 0, 1'b1));
      send_link(make_link(0, 0, 0, 0, 0, -32'sh0003_0001, 1'b0));
      send_link(make_link(5, 5, 5, 5, 5, 5, 1'b0));
      configure(dlcg_pkg::KIND_CABLE, 31'h7FFF_FFFF, 31'h1234);
      send_link(make_link(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 1'b1));
      send_link(make_link(32'h8000_0000, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          0, 1'b0));
   endtask

   task automatic test_rod_directed();
      configure(dlcg_pkg::KIND_ROD, 31'h0002_0000, 31'hABCD);
      send_link(make_link(0, 0, 0, 0, 0, 0, 1'b1));
      send_link(make_link(0, 0, 0, 32'h0002_0000, 0, 0, 1'b0));
      send_link(make_link(0, 0, 0, 0, 32'h0001_0000, 0, 1'b1));
      send_link(make_link(0, 0, 0, 0, 0, 32'h0005_0000, 1'b0));
      send_link(make_link(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 1'b0));
      configure(dlcg_pkg::KIND_ROD, 31'h7FFF_FFFF, '0);
      send_link(make_link(0, 0, 0, 0, 0, 0, 1'b0));
      send_link(make_link(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
      configure(dlcg_pkg::KIND_ROD, '0, '0);
      send_link(make_link(0, 0, 0, 0, 0, 0, 1'b0));
      send_link(make_link(1, 2, 3, -1, -2, -3, 1'b1));
   endtask

   task automatic test_random_links();
      for (int phase = 0; phase < 6; phase++) begin
         configure(phase[0] ? dlcg_pkg::KIND_ROD : dlcg_pkg::KIND_CABLE,
                   (phase == 4) ? 31'h0 : (phase == 5) ? 31'h7FFF_FFFF :
                   31'($urandom_range(0, 31'h0040_0000)), 31'($urandom));
         if (phase == 5) quiet = 1'b1;
         for (int i = 0; i < 115; i++) begin
            send_link(random_link());
            if (phase == 2 && i == 50) drain();
         end
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_cable_directed();
      test_rod_directed();
      test_random_links();
      drain();
      if (mismatch_count == 0 && pending_contacts.size() == 0)
         $display("tb_distance_link_contact_generator_core: PASS");
      else
         $display("tb_distance_link_contact_generator_core: FAIL");
      $finish;
   end

   initial begin
      #3ms;
      $display("tb_distance_link_contact_generator_core: FAIL");
      $finish;
   end
endmodule

[files.f]
src/dlcg_pkg.sv
src/dlcg_if.sv
src/dlcg_sqrt.sv
src/dlcg_div.sv
src/distance_link_contact_generator_core.sv
tb/tb_distance_link_contact_generator_core.sv
